### hdl/lle_pkg.sv
// Package for the linked list engine: types, codes and defaults.
`timescale 1ns / 1ps
package lle_pkg;

  localparam int DEF_CAPACITY   = 64;
  localparam int DEF_VALUE_BITS = 32;

  typedef enum logic [3:0] {
    CMD_APPEND  = 4'd0,
    CMD_SORTED  = 4'd1,
    CMD_DEL_VAL = 4'd2,
    CMD_PREPEND = 4'd3,
    CMD_REVERSE = 4'd4,
    CMD_SEARCH  = 4'd5,
    CMD_INS_AT  = 4'd6,
    CMD_DEL_AT  = 4'd7,
    CMD_DUMP    = 4'd8,
    CMD_CLEAR   = 4'd9
  } lle_cmd_t;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_WALK,
    S_INS,
    S_FIX,
    S_EMIT
  } lle_state_t;

  typedef struct packed {
    logic [3:0]         cmd;
    logic signed [31:0] item_value;
    logic [7:0]         item_index;
  } lle_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [5:0]         found_position;
    logic signed [31:0] element_value;
    logic [6:0]         list_length;
    logic               last;
  } lle_out_t;

endpackage

### hdl/lle_node_mem.sv
// Node table: value and link memories, one registered read port, one write port.
`timescale 1ns / 1ps
module lle_node_mem import lle_pkg::*; #(
  parameter int DEPTH = DEF_CAPACITY,
  parameter int VB    = DEF_VALUE_BITS,
  parameter int AW    = $clog2(DEPTH),
  parameter int LW    = $clog2(DEPTH) + 1
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output logic [VB-1:0] rd_value,
  output logic [LW-1:0] rd_link,
  input  logic [AW-1:0] wr_addr,
  input  logic          link_we,
  input  logic [LW-1:0] link_data,
  input  logic          value_we,
  input  logic [VB-1:0] value_data
);

  logic [VB-1:0] values [DEPTH];
  logic [LW-1:0] links  [DEPTH];

  always_ff @(posedge clk) begin
    if (value_we) values[wr_addr] <= value_data;
    if (link_we) links[wr_addr] <= link_data;
    rd_value <= values[rd_addr];
    rd_link  <= links[rd_addr];
  end

endmodule

### hdl/linked_list_engine.sv
// Top level of the linked list engine: command sequencer over the node table.
`timescale 1ns / 1ps
// Bounded singly linked list held in a node table with a free chain. One
// command is taken at a time. Append, sorted insert, insert at, search, delete,
// reverse and dump walk the chain one node per cycle (dump only while the
// output is free), since each node's link, read from the link memory, is the
// next read address. Dump gives one result per element, last marked. After
// reset, and on a clear command, a pass over every node rebuilds the free
// chain before a command is taken.
module linked_list_engine import lle_pkg::*; #(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  lle_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output lle_out_t out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = AW + 1;
  localparam int SW = $clog2(CAPACITY + 1);
  localparam logic [LW-1:0] NIL = LW'(CAPACITY);

  lle_state_t state, state_next;
  logic [3:0]         cmd_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [7:0]         idx_q;
  logic [LW-1:0]      cur, prev, head, free_head, fix_val;
  logic [AW-1:0]      fix_addr, init_cnt;
  logic [SW-1:0]      steps, count, pos_q;
  logic [1:0]         st_q;
  logic               init_cmd;

  logic [AW-1:0]         rd_addr, wr_addr;
  logic [VALUE_BITS-1:0] rd_value;
  logic [LW-1:0]         rd_link, rl, link_data;
  logic                  link_we, value_we;

  logic ofree, accept, full, is_ins, is_del, is_srch, brk, hit, endw, init_last, emit;

  lle_node_mem #(.DEPTH(CAPACITY), .VB(VALUE_BITS), .AW(AW), .LW(LW)) u_mem (
    .clk       (clk),
    .rd_addr   (rd_addr),
    .rd_value  (rd_value),
    .rd_link   (rd_link),
    .wr_addr   (wr_addr),
    .link_we   (link_we),
    .link_data (link_data),
    .value_we  (value_we),
    .value_data(val_q)
  );

  assign rl        = (rd_link >= NIL) ? NIL : rd_link;
  assign ofree     = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign full      = (count >= SW'(CAPACITY)) || (free_head >= NIL);
  assign is_ins    = cmd_q == CMD_APPEND || cmd_q == CMD_SORTED || cmd_q == CMD_INS_AT;
  assign is_del    = cmd_q == CMD_DEL_VAL || cmd_q == CMD_DEL_AT;
  assign is_srch   = cmd_q == CMD_SEARCH;
  assign brk       = (cmd_q == CMD_SORTED && $signed(rd_value) >= $signed(val_q)) ||
                     (cmd_q == CMD_INS_AT && 9'(steps) >= 9'(idx_q));
  assign hit       = (cmd_q == CMD_DEL_AT) ? (9'(steps) == 9'(idx_q)) : (rd_value == val_q);
  assign endw      = (rl == NIL) || (steps == SW'(CAPACITY - 1));
  assign init_last = (init_cnt == AW'(CAPACITY - 1));
  assign emit      = ofree && (state == S_EMIT || (state == S_WALK && cmd_q == CMD_DUMP));

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: if (init_last) state_next = init_cmd ? S_EMIT : S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          case (in_data.cmd)
            CMD_APPEND, CMD_SORTED, CMD_INS_AT:
              state_next = full ? S_EMIT : ((head == NIL) ? S_INS : S_WALK);
            CMD_PREPEND: state_next = full ? S_EMIT : S_INS;
            CMD_DEL_VAL, CMD_DEL_AT, CMD_SEARCH, CMD_REVERSE, CMD_DUMP:
              state_next = (head == NIL) ? S_EMIT : S_WALK;
            CMD_CLEAR: state_next = S_INIT;
            default: state_next = S_EMIT;
          endcase
        end
      end
      S_WALK: begin
        if (is_ins) begin
          if (brk || endw) state_next = S_INS;
        end else if (is_del || is_srch) begin
          if (hit) state_next = (is_srch || prev == NIL) ? S_EMIT : S_FIX;
          else if (endw) state_next = S_EMIT;
        end else if (cmd_q == CMD_REVERSE) begin
          if (endw) state_next = S_EMIT;
        end else begin
          if (ofree && endw) state_next = S_IDLE;
        end
      end
      S_INS:  state_next = (prev == NIL) ? S_EMIT : S_FIX;
      S_FIX:  state_next = S_EMIT;
      S_EMIT: if (ofree) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rd_addr   = cur[AW-1:0];
    wr_addr   = cur[AW-1:0];
    link_we   = 1'b0;
    link_data = free_head;
    value_we  = 1'b0;
    unique case (state)
      S_INIT: begin
        wr_addr   = init_cnt;
        link_we   = 1'b1;
        link_data = init_last ? NIL : LW'(init_cnt) + LW'(1);
      end
      S_IDLE: begin
        rd_addr = (in_data.cmd == CMD_PREPEND || head == NIL) ? free_head[AW-1:0]
                                                              : head[AW-1:0];
      end
      S_WALK: begin
        if (is_ins) begin
          rd_addr = (brk || endw) ? free_head[AW-1:0] : rl[AW-1:0];
        end else if (is_del || is_srch) begin
          rd_addr = rl[AW-1:0];
          link_we = hit && is_del;
        end else if (cmd_q == CMD_REVERSE) begin
          rd_addr   = rl[AW-1:0];
          link_we   = 1'b1;
          link_data = prev;
        end else begin
          rd_addr = ofree ? rl[AW-1:0] : cur[AW-1:0];
        end
      end
      S_INS: begin
        wr_addr   = free_head[AW-1:0];
        link_we   = 1'b1;
        link_data = cur;
        value_we  = 1'b1;
      end
      S_FIX: begin
        wr_addr   = fix_addr;
        link_we   = 1'b1;
        link_data = fix_val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      init_cnt  <= '0;
      init_cmd  <= 1'b0;
      out_valid <= 1'b0;
      head      <= NIL;
      free_head <= '0;
      count     <= '0;
    end else begin
      state <= state_next;
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_INIT: begin
          if (init_last) begin
            head      <= NIL;
            free_head <= '0;
            count     <= '0;
            init_cmd  <= 1'b0;
            init_cnt  <= '0;
          end else begin
            init_cnt <= init_cnt + AW'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            cmd_q <= in_data.cmd;
            val_q <= VALUE_BITS'(in_data.item_value);
            idx_q <= in_data.item_index;
            cur   <= head;
            prev  <= NIL;
            steps <= '0;
            pos_q <= '0;
            st_q  <= ST_DONE;
            case (in_data.cmd)
              CMD_APPEND, CMD_SORTED, CMD_INS_AT, CMD_PREPEND: if (full) st_q <= ST_FULL;
              CMD_DEL_VAL, CMD_DEL_AT, CMD_SEARCH, CMD_DUMP:
                if (head == NIL) st_q <= ST_EMPTY;
              CMD_CLEAR: init_cmd <= 1'b1;
              default: ;
            endcase
          end
        end
        S_WALK: begin
          if (is_ins) begin
            if (!brk) begin
              prev  <= cur;
              cur   <= rl;
              steps <= steps + SW'(1);
            end
          end else if (is_del || is_srch) begin
            if (hit) begin
              if (is_srch) begin
                pos_q <= steps;
              end else begin
                free_head <= cur;
                count     <= count - SW'(1);
                fix_addr  <= prev[AW-1:0];
                fix_val   <= rl;
                if (prev == NIL) head <= rl;
              end
            end else begin
              prev  <= cur;
              cur   <= rl;
              steps <= steps + SW'(1);
              if (endw) st_q <= ST_ABSENT;
            end
          end else if (cmd_q == CMD_REVERSE) begin
            prev  <= cur;
            cur   <= rl;
            steps <= steps + SW'(1);
            if (endw) head <= cur;
          end else if (ofree) begin
            out_data.status          <= ST_DONE;
            out_data.found_position  <= 6'(steps);
            out_data.element_value   <= 32'(rd_value);
            out_data.list_length     <= 7'(count);
            out_data.last            <= endw;
            prev  <= cur;
            cur   <= rl;
            steps <= steps + SW'(1);
          end
        end
        S_INS: begin
          free_head <= rl;
          count     <= count + SW'(1);
          fix_addr  <= prev[AW-1:0];
          fix_val   <= free_head;
          if (prev == NIL) head <= free_head;
        end
        S_EMIT: begin
          if (ofree) begin
            out_data.status          <= st_q;
            out_data.found_position  <= 6'(pos_q);
            out_data.element_value   <= '0;
            out_data.list_length     <= 7'(count);
            out_data.last            <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
